>>> sv/wrb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wrapping ring buffer package
// Sizes, action codes and the request and response types of the remainder
// unit.
// ----------------------------------------------------------------------------
package wrb_pkg;

  localparam int DEPTH      = 1024;
  localparam int SLOT_W     = $clog2(DEPTH);
  localparam int CNT_W      = SLOT_W + 1;
  localparam int DATA_W     = 64;
  localparam int INDEX_W    = 32;
  localparam int TOTAL_W    = 48;
  localparam int ACTION_W   = 2;
  localparam int DIV_CNT_W  = $clog2(INDEX_W);

  typedef enum logic [ACTION_W-1:0] {
    ACT_PUSH  = 2'd0,
    ACT_READ  = 2'd1,
    ACT_FLUSH = 2'd2,
    ACT_NONE  = 2'd3
  } action_e;

  typedef enum logic {
    STATUS_OK       = 1'b0,
    STATUS_NO_SETUP = 1'b1
  } status_e;

  typedef struct packed {
    logic               start;
    logic [INDEX_W-1:0] dividend;
    logic [CNT_W-1:0]   divisor;
  } wrb_div_req_t;

  typedef struct packed {
    logic              done;
    logic [SLOT_W-1:0] remainder;
  } wrb_div_rsp_t;

endpackage

>>> sv/wrb_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wrapping ring buffer channels
// Valid/ready channel interfaces for the action input and the result output.
// ----------------------------------------------------------------------------
interface wrb_in_if;
  import wrb_pkg::*;

  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [DATA_W-1:0]   element_data;
  logic signed [INDEX_W-1:0] read_index;

  modport source (output valid, action, element_data, read_index, input ready);
  modport sink   (input valid, action, element_data, read_index, output ready);
endinterface

interface wrb_out_if;
  import wrb_pkg::*;

  logic               valid;
  logic               ready;
  logic               status;
  logic [DATA_W-1:0]  read_data;
  logic [SLOT_W-1:0]  slot_used;
  logic [TOTAL_W-1:0] total_pushed;

  modport source (output valid, status, read_data, slot_used, total_pushed, input ready);
  modport sink   (input valid, status, read_data, slot_used, total_pushed, output ready);
endinterface

>>> sv/wrb_rem_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wrapping ring buffer remainder unit
// Restoring shift-subtract remainder of an unsigned index by the slot count,
// one dividend bit per cycle.
// ----------------------------------------------------------------------------
module wrb_rem_unit (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  wrb_pkg::wrb_div_req_t req_i,
  output wrb_pkg::wrb_div_rsp_t rsp_o
);
  import wrb_pkg::*;

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [INDEX_W-1:0]   dvd_q, dvd_d;
  logic [CNT_W-1:0]     dvs_q, dvs_d;
  logic [SLOT_W-1:0]    rem_q, rem_d;
  logic [CNT_W-1:0]     trial;
  logic [CNT_W-1:0]     diff;

  // The partial remainder stays below the divisor, so one more bit always
  // fits in the count width.
  assign trial = {rem_q, dvd_q[INDEX_W-1]};
  assign diff  = trial - dvs_q;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    dvs_d  = dvs_q;
    rem_d  = rem_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      dvd_d  = req_i.dividend;
      dvs_d  = req_i.divisor;
      rem_d  = '0;
    end else if (busy_q) begin
      dvd_d = {dvd_q[INDEX_W-2:0], 1'b0};
      rem_d = (trial >= dvs_q) ? diff[SLOT_W-1:0] : trial[SLOT_W-1:0];
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == DIV_CNT_W'(INDEX_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    dvs_q <= dvs_d;
    rem_q <= rem_d;
  end

  assign rsp_o.done      = done_q;
  assign rsp_o.remainder = rem_q;

endmodule

>>> sv/wrapping_ring_buffer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wrapping ring buffer core
// Overwriting ring buffer with a running push total and reads by signed
// relative index.
// ----------------------------------------------------------------------------
//  Channel   Dir   Handshake      Carries
//  in_i      in    valid/ready    action, element_data, read_index
//  out_o     out   valid/ready    status, read_data, slot_used, total_pushed
//  cfg       in    cfg_we_i       slot count (no wait, no read-back)
//
//  Push, flush, the unused code and any action while the buffer is not set
//  up give their result in the cycle after acceptance.
//  A read has the remainder unit reduce the index, then forms the slot, reads
//  the element memory in ST_SLOT and loads the result register in ST_MEM.
//  No reset sweep: a high-water mark of written slots makes unwritten
//  entries read as zero. One transaction is in flight at a time; a stalled
//  result holds the block until it is taken.
// ----------------------------------------------------------------------------
module wrapping_ring_buffer_core (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [wrb_pkg::CNT_W-1:0] cfg_wdata_i,
  wrb_in_if.sink                 in_i,
  wrb_out_if.source              out_o
);
  import wrb_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_DIV  = 5'b00010,
    ST_SLOT = 5'b00100,
    ST_MEM  = 5'b01000,
    ST_RESP = 5'b10000
  } state_e;

  state_e             state_q, state_d;
  logic [CNT_W-1:0]   elem_count_q, elem_count_d;
  logic [SLOT_W-1:0]  write_slot_q, write_slot_d;
  logic [TOTAL_W-1:0] push_total_q, push_total_d;
  logic [CNT_W-1:0]   hwm_q, hwm_d;
  logic               neg_q, neg_d;
  logic [SLOT_W-1:0]  rd_addr_q, rd_addr_d;
  logic               rd_hit_q, rd_hit_d;
  logic [DATA_W-1:0]  mem_rdata_q;
  logic [DATA_W-1:0]  mem_q [DEPTH];

  logic               status_q, status_d;
  logic [DATA_W-1:0]  rdata_q, rdata_d;
  logic [SLOT_W-1:0]  slot_q, slot_d;
  logic [TOTAL_W-1:0] total_q, total_d;

  logic               accept;
  logic               mem_we;
  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   next_slot;
  logic [CNT_W-1:0]   offset;
  logic [CNT_W:0]     slot_sum;
  logic [CNT_W:0]     slot_wrap;
  logic [INDEX_W-1:0] raw_index;
  wrb_div_req_t       div_req;
  wrb_div_rsp_t       div_rsp;

  assign count     = (elem_count_q > CNT_W'(DEPTH)) ? CNT_W'(DEPTH) : elem_count_q;
  assign accept    = in_i.valid && in_i.ready;
  assign raw_index = in_i.read_index;
  assign next_slot = {1'b0, write_slot_q} + 1'b1;

  // A positive or zero index counts back from the write slot; a negative
  // index counts forward from it.
  assign offset    = neg_q ? {1'b0, div_rsp.remainder}
                           : count - {1'b0, div_rsp.remainder};
  assign slot_sum  = {2'b00, write_slot_q} + {1'b0, offset};
  assign slot_wrap = slot_sum - {1'b0, count};

  assign div_req.start    = accept && (count != '0) && (in_i.action == ACT_READ);
  assign div_req.dividend = raw_index[INDEX_W-1] ? (~raw_index + 1'b1) : raw_index;
  assign div_req.divisor  = count;

  wrb_rem_unit u_rem (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_comb begin
    state_d      = state_q;
    elem_count_d = elem_count_q;
    write_slot_d = write_slot_q;
    push_total_d = push_total_q;
    hwm_d        = hwm_q;
    neg_d        = neg_q;
    rd_addr_d    = rd_addr_q;
    rd_hit_d     = rd_hit_q;
    status_d     = status_q;
    rdata_d      = rdata_q;
    slot_d       = slot_q;
    total_d      = total_q;
    mem_we       = 1'b0;

    if (cfg_we_i) begin
      elem_count_d = cfg_wdata_i;
      write_slot_d = '0;
      push_total_d = '0;
    end

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          status_d = STATUS_OK;
          rdata_d  = '0;
          slot_d   = '0;
          total_d  = '0;
          state_d  = ST_RESP;
          if (count == '0) begin
            status_d = STATUS_NO_SETUP;
          end else begin
            case (in_i.action)
              ACT_PUSH: begin
                mem_we       = 1'b1;
                slot_d       = write_slot_q;
                write_slot_d = (next_slot >= count) ? '0 : next_slot[SLOT_W-1:0];
                push_total_d = push_total_q + 1'b1;
                total_d      = push_total_q + 1'b1;
                if (next_slot > hwm_q) begin
                  hwm_d = next_slot;
                end
              end
              ACT_READ: begin
                neg_d   = raw_index[INDEX_W-1];
                state_d = ST_DIV;
              end
              ACT_FLUSH: begin
                write_slot_d = '0;
                push_total_d = '0;
              end
              default: begin
                slot_d  = write_slot_q;
                total_d = push_total_q;
              end
            endcase
          end
        end
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          rd_addr_d = (slot_sum >= {1'b0, count}) ? slot_wrap[SLOT_W-1:0]
                                                  : slot_sum[SLOT_W-1:0];
          state_d   = ST_SLOT;
        end
      end
      ST_SLOT: begin
        // Entries at or above the high-water mark were never written.
        rd_hit_d = ({1'b0, rd_addr_q} < hwm_q);
        state_d  = ST_MEM;
      end
      ST_MEM: begin
        rdata_d = rd_hit_q ? mem_rdata_q : '0;
        slot_d  = rd_addr_q;
        total_d = push_total_q;
        state_d = ST_RESP;
      end
      ST_RESP: begin
        if (out_o.ready) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      elem_count_q <= '0;
      write_slot_q <= '0;
      push_total_q <= '0;
      hwm_q        <= '0;
    end else begin
      state_q      <= state_d;
      elem_count_q <= elem_count_d;
      write_slot_q <= write_slot_d;
      push_total_q <= push_total_d;
      hwm_q        <= hwm_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q     <= neg_d;
    rd_addr_q <= rd_addr_d;
    rd_hit_q  <= rd_hit_d;
    status_q  <= status_d;
    rdata_q   <= rdata_d;
    slot_q    <= slot_d;
    total_q   <= total_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[write_slot_q] <= in_i.element_data;
    end
    if (state_q == ST_SLOT) begin
      mem_rdata_q <= mem_q[rd_addr_q];
    end
  end

  assign in_i.ready         = (state_q == ST_IDLE);
  assign out_o.valid        = (state_q == ST_RESP);
  assign out_o.status       = status_q;
  assign out_o.read_data    = rdata_q;
  assign out_o.slot_used    = slot_q;
  assign out_o.total_pushed = total_q;

endmodule

>>> sv/wrb_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wrapping ring buffer checker
// Port-level properties of the ring buffer core, bound into the core module.
// ----------------------------------------------------------------------------
module wrb_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic        status_i,
  input logic [63:0] read_data_i,
  input logic [9:0]  slot_used_i,
  input logic [47:0] total_pushed_i
);

  // A result waiting on the output must not vanish before it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  // Only one transaction is in flight: no new item while a result is shown.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_i && out_valid_i))
    else $error("input ready while a result is pending");

  // An accepted item keeps the block busy on the following cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input ready straight after acceptance");

  // A buffer that is not set up reports nothing but the error.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i |->
      (read_data_i == '0) && (slot_used_i == '0) && (total_pushed_i == '0))
    else $error("error result carries data");

endmodule

bind wrapping_ring_buffer_core wrb_checker u_wrb_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_i.valid),
  .in_ready_i     (in_i.ready),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .status_i       (out_o.status),
  .read_data_i    (out_o.read_data),
  .slot_used_i    (out_o.slot_used),
  .total_pushed_i (out_o.total_pushed)
);
